/* hw/rtl/hcfr_pkg.sv */
// ----------------------------------------------------------------------------
// hcfr_pkg: shared types and constants of the header/checksum frame receiver
// Field widths, register codes, reset values and the structs that pass
// between the front parser, the frame queue and the drain back end.
// ----------------------------------------------------------------------------
package hcfr_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned CFG_IDX_W = 1;

    // Number of verified frames that may wait for the back end.
    localparam int unsigned QDEPTH = 2;

    // Reset values of the header registers.
    localparam logic [BYTE_W-1:0] HDR_FIRST_RST  = 8'd170;
    localparam logic [BYTE_W-1:0] HDR_SECOND_RST = 8'd85;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HDR_FIRST  = 1'b0,
        REG_HDR_SECOND = 1'b1
    } cfg_reg_t;

    // What the front end does with one received byte.
    typedef enum logic [1:0] {
        CLS_ADVANCE,
        CLS_COMPLETE,
        CLS_RESTART
    } byte_class_t;

    // Drain sequencer states.
    typedef enum logic {
        DRN_IDLE,
        DRN_READ
    } drain_state_t;

    // Frame buffer write request from the front end.
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
    } buf_wr_t;

    // Frame queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
        logic head;
    } queue_stat_t;

endpackage

/* hw/rtl/header_checksum_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// header_checksum_frame_receiver_unit: header and checksum frame receiver
// The block takes one received byte per cycle. A frame is FRAME_LEN bytes:
// two header bytes that must match the header registers, data bytes, and a
// last byte equal to the 8-bit sum of all bytes before it. A verified frame
// is sent out as FRAME_LEN beats, one per cycle while the sink is ready. With
// the back end idle, the first beat is shown once the frame has passed the
// queue, the drain read state, the read register and the output register.
// Queued frames drain with the drain sequencer idle between them. The
// last beat is marked. A failing byte drops the partial frame silently. Two
// frame banks alternate, so input goes on while a frame drains. Input stalls
// only while two verified frames are held, the one draining and one waiting,
// and resumes the cycle after the last byte of the draining frame is read
// from its bank. Header registers may be written only while the block is
// idle.
// ----------------------------------------------------------------------------
module header_checksum_frame_receiver_unit #(
    parameter int unsigned FRAME_LEN = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hcfr_pkg::BYTE_W-1:0]       rx_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hcfr_pkg::BYTE_W-1:0]       frame_byte,
    output logic [hcfr_pkg::POS_W-1:0]        byte_position,
    output logic                              frame_last,
    input  logic                              cfg_we,
    input  logic [hcfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hcfr_pkg::BYTE_W-1:0]       cfg_data
);

    localparam int unsigned POS_W = hcfr_pkg::POS_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    hcfr_pkg::queue_stat_t q_stat;
    hcfr_pkg::buf_wr_t     buf_wr;
    logic                  q_push;
    logic                  q_pop;
    logic                  push_bank;

    // Parser front end.
    hcfr_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .push_bank (push_bank),
        .buf_wr    (buf_wr)
    );

    // Verified frame queue.
    hcfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_bank (push_bank),
        .pop       (q_pop),
        .stat      (q_stat)
    );

    // Frame buffer and drain back end.
    hcfr_back #(
        .FRAME_LEN (FRAME_LEN)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .buf_wr        (buf_wr),
        .q_stat        (q_stat),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .frame_last    (frame_last)
    );

    // A verified frame is never pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("frame pushed into full queue");

    // A bank is released only when one is queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("frame queue popped while empty");

    // The last-beat mark sits exactly on the checksum position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_last == (byte_position == LAST_POS)))
        else $error("frame_last does not match byte_position");

    // Once the checksum beat is taken, the next beat shown starts a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && frame_last) ##1 out_valid
            |-> (byte_position == '0))
        else $error("frame drain did not restart at position zero");

endmodule

/* hw/rtl/hcfr_front.sv */
// ----------------------------------------------------------------------------
// hcfr_front: byte parser of the frame receiver
// Accepts received bytes, checks the two header bytes and the checksum,
// writes every byte into the active buffer bank and hands a verified bank
// to the frame queue.
// ----------------------------------------------------------------------------
module hcfr_front #(
    parameter int unsigned FRAME_LEN = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [hcfr_pkg::BYTE_W-1:0]         rx_byte,
    input  logic                                cfg_we,
    input  logic [hcfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hcfr_pkg::BYTE_W-1:0]         cfg_data,
    input  hcfr_pkg::queue_stat_t               q_stat,
    output logic                                q_push,
    output logic                                push_bank,
    output hcfr_pkg::buf_wr_t                   buf_wr
);

    localparam int unsigned POS_W = hcfr_pkg::POS_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_HDR0 = '0;
    localparam logic [POS_W-1:0] POS_HDR1 = POS_W'(1);

    logic [hcfr_pkg::BYTE_W-1:0] hdr_first_reg;
    logic [hcfr_pkg::BYTE_W-1:0] hdr_second_reg;
    logic [POS_W-1:0]            pos_reg;
    logic [POS_W-1:0]            pos_next;
    logic [hcfr_pkg::BYTE_W-1:0] sum_reg;
    logic [hcfr_pkg::BYTE_W-1:0] sum_next;
    logic                        bank_reg;
    logic                        bank_next;
    logic                        accept;
    hcfr_pkg::byte_class_t       byte_cls;

    // Both buffer banks are taken while the queue is full.
    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= hcfr_pkg::HDR_FIRST_RST;
            hdr_second_reg <= hcfr_pkg::HDR_SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (hcfr_pkg::cfg_reg_t'(cfg_index))
                hcfr_pkg::REG_HDR_FIRST:  hdr_first_reg  <= cfg_data;
                hcfr_pkg::REG_HDR_SECOND: hdr_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the incoming byte against its frame position.
    always_comb
    begin
        byte_cls = hcfr_pkg::CLS_RESTART;
        if (pos_reg == LAST_POS)
        begin
            if (rx_byte == sum_reg)
            begin
                byte_cls = hcfr_pkg::CLS_COMPLETE;
            end
        end
        else if (pos_reg == POS_HDR0)
        begin
            if (rx_byte == hdr_first_reg)
            begin
                byte_cls = hcfr_pkg::CLS_ADVANCE;
            end
        end
        else if (pos_reg == POS_HDR1)
        begin
            if (rx_byte == hdr_second_reg)
            begin
                byte_cls = hcfr_pkg::CLS_ADVANCE;
            end
        end
        else
        begin
            byte_cls = hcfr_pkg::CLS_ADVANCE;
        end
    end

    // Position, running sum and bank update.
    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        bank_next = bank_reg;
        if (accept)
        begin
            unique case (byte_cls)
                hcfr_pkg::CLS_ADVANCE:
                begin
                    pos_next = pos_reg + POS_W'(1);
                    sum_next = sum_reg + rx_byte;
                end
                hcfr_pkg::CLS_COMPLETE:
                begin
                    pos_next  = '0;
                    sum_next  = '0;
                    bank_next = !bank_reg;
                end
                default:
                begin
                    pos_next = '0;
                    sum_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            bank_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            bank_reg <= bank_next;
        end
    end

    // Every accepted byte lands in the active bank.
    always_comb
    begin
        buf_wr.en   = accept;
        buf_wr.bank = bank_reg;
        buf_wr.pos  = pos_reg;
        buf_wr.data = rx_byte;
    end

    assign q_push    = accept && (byte_cls == hcfr_pkg::CLS_COMPLETE);
    assign push_bank = bank_reg;

endmodule

/* hw/rtl/hcfr_queue.sv */
// ----------------------------------------------------------------------------
// hcfr_queue: queue of verified frame banks
// Holds the bank numbers of frames that passed the checksum, in arrival
// order, until the back end has drained them.
// ----------------------------------------------------------------------------
module hcfr_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  push_bank,
    input  logic                  pop,
    output hcfr_pkg::queue_stat_t stat
);

    localparam int unsigned PTR_W = $clog2(hcfr_pkg::QDEPTH);

    logic             entry_reg [hcfr_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg;
    logic [PTR_W:0]   cnt_next;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_bank;
        end
    end

    // Occupancy bookkeeping.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + (PTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        stat.full  = (cnt_reg == (PTR_W + 1)'(hcfr_pkg::QDEPTH));
        stat.empty = (cnt_reg == '0);
        stat.head  = entry_reg[rd_ptr_reg];
    end

endmodule

/* hw/rtl/hcfr_back.sv */
// ----------------------------------------------------------------------------
// hcfr_back: frame buffer and drain sequencer
// Holds two frame banks, reads the bank at the head of the queue out in
// position order and presents each byte through an output register.
// ----------------------------------------------------------------------------
module hcfr_back #(
    parameter int unsigned FRAME_LEN = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hcfr_pkg::buf_wr_t             buf_wr,
    input  hcfr_pkg::queue_stat_t         q_stat,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hcfr_pkg::BYTE_W-1:0]   frame_byte,
    output logic [hcfr_pkg::POS_W-1:0]    byte_position,
    output logic                          frame_last
);

    localparam int unsigned POS_W     = hcfr_pkg::POS_W;
    localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
    localparam int unsigned MEM_DEPTH = 2 * (2 ** IDX_W);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    logic [hcfr_pkg::BYTE_W-1:0] mem [MEM_DEPTH];

    hcfr_pkg::drain_state_t      state_reg;
    hcfr_pkg::drain_state_t      state_next;
    logic [POS_W-1:0]            cnt_reg;
    logic [POS_W-1:0]            cnt_next;
    logic                        advance;
    logic                        rd_en;
    logic                        rd_valid_reg;
    logic [hcfr_pkg::BYTE_W-1:0] rd_data_reg;
    logic [POS_W-1:0]            rd_pos_reg;
    logic                        rd_last_reg;
    logic                        out_valid_reg;
    logic [hcfr_pkg::BYTE_W-1:0] out_byte_reg;
    logic [POS_W-1:0]            out_pos_reg;
    logic                        out_last_reg;

    // The read stage moves on whenever the output register is free or taken.
    assign advance = !out_valid_reg || out_ready;

    // Frame buffer write port.
    always_ff @(posedge clk)
    begin
        if (buf_wr.en)
        begin
            mem[{buf_wr.bank, buf_wr.pos[IDX_W-1:0]}] <= buf_wr.data;
        end
    end

    // Frame buffer read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[{q_stat.head, cnt_reg[IDX_W-1:0]}];
            rd_pos_reg  <= cnt_reg;
            rd_last_reg <= (cnt_reg == LAST_POS);
        end
    end

    // Drain sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hcfr_pkg::DRN_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = hcfr_pkg::DRN_READ;
                end
            end
            hcfr_pkg::DRN_READ:
            begin
                if (advance && (cnt_reg == LAST_POS))
                begin
                    state_next = hcfr_pkg::DRN_IDLE;
                end
            end
            default: state_next = hcfr_pkg::DRN_IDLE;
        endcase
    end

    // Drain sequencer: outputs. The queue entry is released only after the
    // last byte of its bank has been read, so the front cannot reuse it early.
    always_comb
    begin
        rd_en    = 1'b0;
        cnt_next = cnt_reg;
        unique case (state_reg)
            hcfr_pkg::DRN_IDLE:
            begin
                cnt_next = '0;
            end
            hcfr_pkg::DRN_READ:
            begin
                rd_en = advance;
                if (advance)
                begin
                    cnt_next = cnt_reg + POS_W'(1);
                end
            end
            default: cnt_next = '0;
        endcase
    end

    assign q_pop = rd_en && (cnt_reg == LAST_POS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcfr_pkg::DRN_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Valid flags of the read stage and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rd_valid_reg  <= rd_en;
            out_valid_reg <= rd_valid_reg;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (advance && rd_valid_reg)
        begin
            out_byte_reg <= rd_data_reg;
            out_pos_reg  <= rd_pos_reg;
            out_last_reg <= rd_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_byte    = out_byte_reg;
    assign byte_position = out_pos_reg;
    assign frame_last    = out_last_reg;

endmodule
